/* rtl/core/hsaso_pkg.sv */
// Package: shared types, constants and lookup functions for the Hall observer.
`default_nettype none
package hsaso_pkg;
	localparam int ANGLE_FRAC_BITS_DEF = 24;
	localparam int TICK_COUNT_WIDTH_DEF = 24;
	localparam int SPEED_W = 32;
	localparam int SCALE_W = 31;
	localparam int GAIN_W = 16;
	localparam int CFG_W = 24;
	localparam int PADDR_W = 5;

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_SCALE = 3'd1;
	localparam logic [2:0] REG_APS = 3'd2;
	localparam logic [2:0] REG_OFFSET = 3'd3;
	localparam logic [2:0] REG_TIMEOUT = 3'd4;
	localparam logic [2:0] REG_GAIN = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_FILT, ST_STEP, ST_CLAMP, ST_OUT
	} state_t;

	typedef struct packed {
		logic load;       // latch hall, classify
		logic div_start;
		logic filt;       // filter update + resync
		logic step;       // integration + timeout
		logic clamp;      // compute held outputs
	} cmd_t;

	typedef struct packed {
		logic run;        // enabled and non-fault
		logic edge_div;   // adjacent edge with nonzero count
		logic same;       // no hall change
		logic div_done;
	} sts_t;

	function automatic logic [3:0] centre12(input logic [2:0] h);
		case (h)
			3'd1: centre12 = 4'd11;
			3'd2: centre12 = 4'd7;
			3'd3: centre12 = 4'd9;
			3'd4: centre12 = 4'd3;
			3'd5: centre12 = 4'd1;
			3'd6: centre12 = 4'd5;
			default: centre12 = 4'd0;
		endcase
	endfunction

	// +1 forward, -1 reverse, 0 none; encoded {valid, reverse}
	function automatic logic [1:0] dir_lut(input logic [2:0] p, input logic [2:0] c);
		case ({p, c})
			6'o13, 6'o26, 6'o32, 6'o45, 6'o51, 6'o64: dir_lut = 2'b11;
			6'o15, 6'o23, 6'o31, 6'o46, 6'o54, 6'o62: dir_lut = 2'b10;
			default: dir_lut = 2'b00;
		endcase
	endfunction
endpackage
`default_nettype wire

/* rtl/core/hsaso_ctrl.sv */
// Controller FSM sequencing one tick through the datapath.
`default_nettype none
module hsaso_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic out_fire,
	input  wire hsaso_pkg::sts_t sts,
	output hsaso_pkg::cmd_t cmd,
	output logic busy,
	output logic out_valid
);
	import hsaso_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!sts.run) state_d = ST_OUT;
				else if (sts.same) state_d = ST_STEP;
				else if (sts.edge_div) begin
					cmd.div_start = 1'b1;
					state_d = ST_FILT;
				end else state_d = ST_CLAMP;
			end
			ST_FILT: begin
				if (sts.div_done) begin
					cmd.filt = 1'b1;
					state_d = ST_CLAMP;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_div_only_edge: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> sts.edge_div && sts.run)
		else $error("divider started without edge");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_fire) |=> out_valid)
		else $error("result dropped");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy)
		else $error("load while busy");
endmodule
`default_nettype wire

/* rtl/core/hsaso_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module hsaso_div #(
	parameter int TW = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [hsaso_pkg::SCALE_W-1:0] num,
	input  wire logic [TW-1:0] den,
	output logic done,
	output logic [hsaso_pkg::SCALE_W-1:0] quo
);
	import hsaso_pkg::*;
	localparam int CW = $clog2(SCALE_W + 1);
	logic [TW:0] rem_q;
	logic [SCALE_W-1:0] q_q;
	logic [TW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [TW:0] sh;
	logic ge;

	assign sh = {rem_q[TW-1:0], q_q[SCALE_W-1]};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(SCALE_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? sh - {1'b0, den_q} : sh;
			q_q <= {q_q[SCALE_W-2:0], ge};
		end
	end

	assign done = !busy_q && !start;
	assign quo = q_q;
endmodule
`default_nettype wire

/* rtl/core/hsaso_dp.sv */
// Datapath: observer state, filter, integration, clamp and held outputs.
`default_nettype none
module hsaso_dp #(
	parameter int AFB = 24,
	parameter int TW = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire hsaso_pkg::cmd_t cmd,
	output hsaso_pkg::sts_t sts,
	input  wire logic [2:0] hall_in,
	input  wire logic en,
	input  wire logic [hsaso_pkg::SCALE_W-1:0] scale,
	input  wire logic [hsaso_pkg::CFG_W-1:0] aps,
	input  wire logic [hsaso_pkg::CFG_W-1:0] offset,
	input  wire logic [hsaso_pkg::CFG_W-1:0] tmo,
	input  wire logic [hsaso_pkg::GAIN_W-1:0] gain,
	output logic [23:0] angle_out,
	output logic signed [31:0] speed_out
);
	import hsaso_pkg::*;
	localparam logic [AFB:0] ONE = (AFB+1)'(1) << AFB;
	localparam logic [AFB:0] HALF = ONE >> 1;
	// k/12 turn, rounded to nearest
	localparam logic [AFB-1:0] C1 = AFB'((64'd2 * (64'd1 << AFB) + 64'd12) / 64'd24);
	localparam logic [AFB-1:0] C3 = AFB'((64'd6 * (64'd1 << AFB) + 64'd12) / 64'd24);
	localparam logic [AFB-1:0] C5 = AFB'((64'd10 * (64'd1 << AFB) + 64'd12) / 64'd24);
	localparam logic [AFB-1:0] C7 = AFB'((64'd14 * (64'd1 << AFB) + 64'd12) / 64'd24);
	localparam logic [AFB-1:0] C9 = AFB'((64'd18 * (64'd1 << AFB) + 64'd12) / 64'd24);
	localparam logic [AFB-1:0] C11 = AFB'((64'd22 * (64'd1 << AFB) + 64'd12) / 64'd24);
	localparam logic [AFB-1:0] MARGIN = C1;
	localparam logic signed [AFB+1:0] MARGIN_S = $signed((AFB+2)'(MARGIN));

	logic [2:0] last_q, hall_q;
	logic [TW-1:0] ticks_q;
	logic [AFB-1:0] ang_q, held_ang_q;
	logic signed [31:0] spd_q, held_spd_q;
	logic run_q, same_q, ediv_q, rev_q, first_q;
	logic div_done;
	logic [SCALE_W-1:0] quo;
	logic [1:0] dir;
	logic [AFB-1:0] centre;

	assign dir = dir_lut(last_q, hall_in);

	always_comb begin
		case (centre12(hall_q))
			4'd1: centre = C1;
			4'd3: centre = C3;
			4'd5: centre = C5;
			4'd7: centre = C7;
			4'd9: centre = C9;
			4'd11: centre = C11;
			default: centre = '0;
		endcase
	end

	hsaso_div #(.TW(TW)) u_div (
		.clk, .arst_n, .start(cmd.div_start), .num(scale), .den(ticks_q),
		.done(div_done), .quo
	);

	// filter
	logic signed [33:0] raw, dx;
	logic signed [50:0] prod;
	logic signed [34:0] fsum;
	logic signed [31:0] fnew;
	assign raw = rev_q ? -$signed({3'b0, quo}) : $signed({3'b0, quo});
	assign dx = raw - 34'(spd_q);
	assign prod = dx * $signed({1'b0, gain});
	assign fsum = 35'(spd_q) + 35'(prod >>> 16);
	assign fnew = (fsum > 35'sd2147483647) ? 32'sh7FFFFFFF :
		(fsum < -35'sd2147483648) ? 32'sh80000000 : fsum[31:0];

	// integration
	logic signed [56:0] sp;
	logic signed [32:0] stp;
	logic [TW-1:0] tinc;
	assign sp = spd_q * $signed({1'b0, aps});
	assign stp = 33'(sp >>> 24);
	assign tinc = (&ticks_q) ? ticks_q : ticks_q + 1'b1;

	// first valid state after reset: snap to centre (clamp then sees err 0)
	logic snap;
	logic [AFB-1:0] clamp_ang;
	assign snap = !same_q && !ediv_q && first_q;
	assign clamp_ang = snap ? centre : ang_q;

	// clamp
	logic [AFB-1:0] diff;
	logic signed [AFB+1:0] err;
	assign diff = clamp_ang - centre;
	always_comb begin
		err = (AFB+2)'({1'b0, diff});
		if ({1'b0, diff} > HALF) err = err - $signed((AFB+2)'(ONE));
		if (err > MARGIN_S) err = MARGIN_S;
		if (err < -MARGIN_S) err = -MARGIN_S;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0; ticks_q <= '0; ang_q <= '0; spd_q <= '0;
			held_ang_q <= '0; held_spd_q <= '0;
			run_q <= 1'b0; same_q <= 1'b0; ediv_q <= 1'b0; rev_q <= 1'b0;
			first_q <= 1'b0; hall_q <= '0;
		end else begin
			if (cmd.load) begin
				hall_q <= hall_in;
				run_q <= en && hall_in != 3'd0 && hall_in != 3'd7;
				same_q <= hall_in == last_q;
				ediv_q <= dir[1] && ticks_q != '0;
				rev_q <= dir[0];
				first_q <= last_q == 3'd0;
			end
			if (cmd.filt) begin
				spd_q <= fnew;
				ang_q <= rev_q ? centre + MARGIN : centre - MARGIN;
			end
			if (cmd.step) begin
				ticks_q <= tinc;
				ang_q <= ang_q + stp[AFB-1:0];
				if (32'(tinc) > 32'(tmo)) spd_q <= '0;
			end
			if (cmd.clamp) begin
				if (!same_q) begin
					last_q <= hall_q;
					ticks_q <= '0;
				end
				if (snap) ang_q <= centre;
				held_spd_q <= spd_q;
				held_ang_q <= centre + err[AFB-1:0] + AFB'(offset);
			end
		end
	end

	assign sts = '{run: run_q, edge_div: ediv_q, same: same_q, div_done: div_done};
	assign angle_out = 24'(held_ang_q);
	assign speed_out = held_spd_q;
endmodule
`default_nettype wire

/* rtl/core/hall_sensor_angle_speed_observer.sv */
// Top level: APB registers, stream handshake, controller and datapath.
// Sequence per accepted transaction: disabled or fault goes straight to the result; a
// non-adjacent or first edge clamps; within a sector it integrates, then clamps; an adjacent
// edge runs the 31-bit divider and the filter, then clamps. Throughput: one transaction at a
// time; the next is taken in the cycle after the result transaction completes.
// Reset: arst_n async low; state and registers cleared, timeout limit and gain all ones.
`default_nettype none
module hall_sensor_angle_speed_observer #(
	parameter int ANGLE_FRAC_BITS = hsaso_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int TICK_COUNT_WIDTH = hsaso_pkg::TICK_COUNT_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [7:0] s_tdata,    // [2:0] hall code
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [63:0] m_tdata,        // [23:0] elec_angle, [55:24] speed
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [hsaso_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import hsaso_pkg::*;
	logic en_q;
	logic [SCALE_W-1:0] scale_q;
	logic [CFG_W-1:0] aps_q, off_q, tmo_q;
	logic [GAIN_W-1:0] gain_q;
	logic busy, wr;
	cmd_t cmd;
	sts_t sts;
	logic [23:0] ang;
	logic signed [31:0] spd;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0; scale_q <= '0; aps_q <= '0; off_q <= '0;
			tmo_q <= '1; gain_q <= '1;
		end else if (wr) begin
			case (paddr[4:2])
				REG_ENABLE: en_q <= pwdata[0];
				REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
				REG_APS: aps_q <= pwdata[CFG_W-1:0];
				REG_OFFSET: off_q <= pwdata[CFG_W-1:0];
				REG_TIMEOUT: tmo_q <= pwdata[CFG_W-1:0];
				REG_GAIN: gain_q <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[4:2])
			REG_ENABLE: prdata = {31'b0, en_q};
			REG_SCALE: prdata = {1'b0, scale_q};
			REG_APS: prdata = {8'b0, aps_q};
			REG_OFFSET: prdata = {8'b0, off_q};
			REG_TIMEOUT: prdata = {8'b0, tmo_q};
			REG_GAIN: prdata = {16'b0, gain_q};
			default: prdata = '0;
		endcase
	end

	assign s_tready = !busy;

	hsaso_ctrl u_ctrl (
		.clk, .arst_n, .in_fire(s_tvalid && s_tready),
		.out_fire(m_tvalid && m_tready), .sts, .cmd, .busy, .out_valid(m_tvalid)
	);

	hsaso_dp #(.AFB(ANGLE_FRAC_BITS), .TW(TICK_COUNT_WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .sts, .hall_in(s_tdata[2:0]), .en(en_q),
		.scale(scale_q), .aps(aps_q), .offset(off_q), .tmo(tmo_q), .gain(gain_q),
		.angle_out(ang), .speed_out(spd)
	);

	assign m_tdata = {8'b0, spd, ang};
endmodule
`default_nettype wire
